// ===== rtl/elfv_pkg.sv =====
// Shared types and constants for the ELF64 image validator.
// No dependencies; imported by every module under rtl/.
package elfv_pkg;

  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] PAGE_MASK   = 64'(PAGE_BYTES - 1);
  localparam logic [63:0] HDR_BYTES   = 64'd64;
  localparam logic [21:0] ENT_BYTES   = 22'd56;
  localparam logic [15:0] ENT_SIZE    = 16'd56;
  localparam logic [31:0] ELF_MAGIC   = 32'h464C457F;
  localparam logic [7:0]  CLASS_64    = 8'd2;
  localparam logic [7:0]  DATA_LSB    = 8'd1;
  localparam logic [15:0] MACH_AARCH64 = 16'd183;
  localparam logic [31:0] TYPE_EXEC   = 32'd2;
  localparam logic [31:0] SEG_LOAD    = 32'd1;

  localparam logic ACT_HEADER  = 1'b0;
  localparam logic ACT_SEGMENT = 1'b1;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_NOT_ELF    = 4'd1,
    ST_CLASS      = 4'd2,
    ST_NOT_EXEC   = 4'd3,
    ST_BAD_TABLE  = 4'd4,
    ST_SEG_BOUNDS = 4'd5,
    ST_OFFSETS    = 4'd6,
    ST_NO_LOAD    = 4'd7,
    ST_UNALIGNED  = 4'd8,
    ST_ENTRY      = 4'd9
  } elfv_status_t;

  typedef struct packed {
    logic        action;
    logic [47:0] ident_bytes;
    logic [31:0] kind_code;
    logic [15:0] machine_code;
    logic [15:0] table_entry_size;
    logic [15:0] table_entry_count;
    logic [63:0] offset_value;
    logic [63:0] address_value;
    logic [63:0] phys_address;
    logic [63:0] file_length;
    logic [63:0] mem_length;
  } elfv_req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        done_res;
    logic [15:0] bad_segment;
    logic [63:0] virt_base;
    logic [63:0] virt_end;
    logic [63:0] phys_base;
    logic [63:0] entry_point;
  } elfv_res_t;

  // classified request handed from front to back
  typedef struct packed {
    logic         is_header;
    elfv_status_t hdr_status;
    logic [15:0]  count;
    logic [63:0]  addr;
    logic [63:0]  phys;
    logic         seg_load;
    logic         seg_bad;
    logic [63:0]  seg_end;
    logic [63:0]  seg_delta;
  } elfv_work_t;

  function automatic logic [63:0] page_round_up(input logic [63:0] v);
    page_round_up = (v + PAGE_MASK) & ~PAGE_MASK;
  endfunction

endpackage

// ===== rtl/elfv_front.sv =====
// Front end: holds image_size and classifies each request.
// Depends on elfv_pkg.
module elfv_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data,
  input  elfv_pkg::elfv_req_t req,
  output elfv_pkg::elfv_work_t work
);
  import elfv_pkg::*;

  logic [63:0] image_size;
  logic [63:0] room;
  logic [21:0] tbl_bytes;
  logic [64:0] end_sum;
  logic        past_image;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
    end else if (cfg_wr_en) begin
      image_size <= cfg_wr_data;
    end
  end

  assign room       = image_size - req.offset_value;
  assign past_image = req.offset_value > image_size;
  assign tbl_bytes  = 22'(req.table_entry_count) * ENT_BYTES;
  assign end_sum    = {1'b0, req.address_value} + {1'b0, req.mem_length};

  always_comb begin
    work.is_header = (req.action == ACT_HEADER);
    if (image_size < HDR_BYTES || req.ident_bytes[31:0] != ELF_MAGIC) begin
      work.hdr_status = ST_NOT_ELF;
    end else if (req.ident_bytes[39:32] != CLASS_64 || req.ident_bytes[47:40] != DATA_LSB ||
                 req.machine_code != MACH_AARCH64) begin
      work.hdr_status = ST_CLASS;
    end else if (req.kind_code != TYPE_EXEC) begin
      work.hdr_status = ST_NOT_EXEC;
    end else if (req.table_entry_size != ENT_SIZE || past_image ||
                 room < {42'd0, tbl_bytes}) begin
      work.hdr_status = ST_BAD_TABLE;
    end else begin
      work.hdr_status = ST_OK;
    end
    work.count     = req.table_entry_count;
    work.addr      = req.address_value;
    work.phys      = req.phys_address;
    work.seg_load  = (req.kind_code == SEG_LOAD) && (req.mem_length != '0);
    work.seg_bad   = past_image || (req.file_length > room) ||
                     (req.file_length > req.mem_length) || end_sum[64];
    work.seg_end   = end_sum[63:0];
    work.seg_delta = req.address_value - req.phys_address;
  end

endmodule

// ===== rtl/elfv_queue.sv =====
// Short FIFO of classified requests between front and back.
// Depends on elfv_pkg.
module elfv_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  elfv_pkg::elfv_work_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output elfv_pkg::elfv_work_t pop_data
);
  import elfv_pkg::*;

  elfv_work_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/elfv_back.sv =====
// Back end: run state, segment accounting, final checks, result register.
// Depends on elfv_pkg.
module elfv_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  elfv_pkg::elfv_work_t w,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output elfv_pkg::elfv_res_t  out_res
);
  import elfv_pkg::*;

  logic [15:0]  entries_left, entries_left_next;
  logic [15:0]  entry_index, entry_index_next;
  logic [63:0]  low_virt, low_virt_next;
  logic [63:0]  low_phys, low_phys_next;
  logic [63:0]  low_delta, low_delta_next;
  logic [63:0]  high_virt, high_virt_next;
  logic [63:0]  saved_entry, saved_entry_next;
  logic         load_seen, load_seen_next;
  logic         finished, finished_next;
  elfv_status_t verdict, verdict_next;
  logic [15:0]  fault_index, fault_index_next;
  logic         do_finish;
  logic [63:0]  vend;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    entries_left_next = entries_left;
    entry_index_next  = entry_index;
    low_virt_next     = low_virt;
    low_phys_next     = low_phys;
    low_delta_next    = low_delta;
    high_virt_next    = high_virt;
    saved_entry_next  = saved_entry;
    load_seen_next    = load_seen;
    finished_next     = finished;
    verdict_next      = verdict;
    fault_index_next  = fault_index;
    do_finish         = 1'b0;

    if (w.is_header) begin
      entries_left_next = '0;
      entry_index_next  = '0;
      low_virt_next     = '1;
      low_phys_next     = '0;
      high_virt_next    = '0;
      saved_entry_next  = w.addr;
      load_seen_next    = 1'b0;
      finished_next     = 1'b0;
      verdict_next      = ST_OK;
      fault_index_next  = '0;
      if (w.hdr_status != ST_OK) begin
        finished_next = 1'b1;
        verdict_next  = w.hdr_status;
      end else begin
        entries_left_next = w.count;
        do_finish         = (w.count == '0);
      end
    end else if (!finished) begin
      if (entries_left == '0) begin
        finished_next    = 1'b1;
        verdict_next     = ST_BAD_TABLE;
        fault_index_next = '0;
      end else if (w.seg_load && w.seg_bad) begin
        finished_next    = 1'b1;
        verdict_next     = ST_SEG_BOUNDS;
        fault_index_next = entry_index;
      end else if (w.seg_load && load_seen && w.seg_delta != low_delta) begin
        finished_next    = 1'b1;
        verdict_next     = ST_OFFSETS;
        fault_index_next = entry_index;
      end else begin
        if (w.seg_load) begin
          if (!load_seen || w.addr < low_virt) begin
            low_virt_next  = w.addr;
            low_phys_next  = w.phys;
            low_delta_next = w.seg_delta;
          end
          load_seen_next = 1'b1;
          if (w.seg_end > high_virt) begin
            high_virt_next = w.seg_end;
          end
        end
        entry_index_next  = entry_index + 16'd1;
        entries_left_next = entries_left - 16'd1;
        do_finish         = (entries_left == 16'd1);
      end
    end

    vend = page_round_up(high_virt_next);

    if (do_finish) begin
      finished_next = 1'b1;
      if (!load_seen_next) begin
        verdict_next = ST_NO_LOAD;
      end else if ((low_virt_next & PAGE_MASK) != '0 || (low_phys_next & PAGE_MASK) != '0) begin
        verdict_next = ST_UNALIGNED;
      end else if (saved_entry_next < low_virt_next || saved_entry_next >= vend) begin
        verdict_next = ST_ENTRY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_left <= '0;
      entry_index  <= '0;
      low_virt     <= '1;
      low_phys     <= '0;
      high_virt    <= '0;
      saved_entry  <= '0;
      load_seen    <= 1'b0;
      finished     <= 1'b0;
      verdict      <= ST_OK;
      fault_index  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        entries_left <= entries_left_next;
        entry_index  <= entry_index_next;
        low_virt     <= low_virt_next;
        low_phys     <= low_phys_next;
        high_virt    <= high_virt_next;
        saved_entry  <= saved_entry_next;
        load_seen    <= load_seen_next;
        finished     <= finished_next;
        verdict      <= verdict_next;
        fault_index  <= fault_index_next;
      end
      out_valid <= pop || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      low_delta           <= low_delta_next;
      out_res.status      <= 4'(verdict_next);
      out_res.done_res    <= finished_next;
      out_res.bad_segment <= fault_index_next;
      out_res.virt_base   <= load_seen_next ? low_virt_next : '0;
      out_res.virt_end    <= vend;
      out_res.phys_base   <= load_seen_next ? low_phys_next : '0;
      out_res.entry_point <= saved_entry_next;
    end
  end

  a_fault_only_seg: assert property (@(posedge clk) disable iff (rst)
    (fault_index != '0) |-> (verdict == ST_SEG_BOUNDS || verdict == ST_OFFSETS))
    else $error("bad segment index without a segment error");

  a_verdict_done: assert property (@(posedge clk) disable iff (rst)
    (verdict != ST_OK) |-> finished)
    else $error("error status while run still open");

  a_high_needs_load: assert property (@(posedge clk) disable iff (rst)
    !load_seen |-> (high_virt == '0))
    else $error("segment end recorded without a loadable segment");

  a_finished_holds: assert property (@(posedge clk) disable iff (rst)
    (pop && finished && !w.is_header) |=> (finished && $stable(verdict)))
    else $error("finished run changed by a segment request");

endmodule

// ===== rtl/elf64_image_validator.sv =====
// Top level of the ELF64 image validator: front, queue and back.
// Depends on elfv_pkg, elfv_front, elfv_queue, elfv_back.
//
//   channel | signals                     | direction
//   cfg     | cfg_wr_en, cfg_wr_data      | in, write image_size
//   in      | in_valid, in_stall, in_req  | requests in, stall out
//   out     | out_valid, out_stall, out_res | results out, stall in
//
// One request per cycle sustained unless in_stall or out_stall holds it; the queue is
// written at the accept edge; back-end state, out_valid and result register on the pop.
// in_stall rises only when the queue is full; the output register holds while out_valid and out_stall.
// Reset is synchronous on rst and clears image_size and the run state other than low_delta.
module elf64_image_validator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [63:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  elfv_pkg::elfv_req_t in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output elfv_pkg::elfv_res_t out_res
);
  import elfv_pkg::*;

  elfv_work_t front_work;
  elfv_work_t q_data;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  assign in_stall = q_full;

  elfv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (in_req),
    .work        (front_work)
  );

  elfv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (front_work),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  elfv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .w         (q_data),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
